/* rtl/gbwf_pkg.sv */
// ----------------------------------------------------------------------------
// gbwf_pkg
// Shared types and constants for the grid basin water fill block.
// ----------------------------------------------------------------------------
package gbwf_pkg;

    localparam int CFG_W    = 7;
    localparam int IN_HW    = 16;
    localparam int WATER_W  = 28;
    localparam int OUT_DW   = 32;
    localparam int CFG_IW   = 1;

    localparam logic [WATER_W-1:0] WATER_MAX = 28'hFFFFFFF;

    localparam logic [CFG_IW-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_COLS = 1'b1;

    typedef enum logic [4:0] {
        S_LOAD,
        S_CLEAR,
        S_BSCAN,
        S_BPUSH,
        S_BNEXT,
        S_PU_START,
        S_PU_UP,
        S_PU_CMP,
        S_POP_RD0,
        S_POP_RD1,
        S_POP_LAST,
        S_SD_CHK,
        S_SD_L,
        S_SD_R,
        S_SD_DEC,
        S_NB_ADDR,
        S_NB_RD,
        S_NB_CHK,
        S_NB_NEXT,
        S_DONE
    } state_t;

endpackage

/* rtl/gbwf_ram.sv */
// ----------------------------------------------------------------------------
// gbwf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/grid_basin_water_fill.sv */
// ----------------------------------------------------------------------------
// grid_basin_water_fill
// Trapped water over a height grid by min-heap flood fill from the border.
// ----------------------------------------------------------------------------
// Usage: set grid_rows and grid_cols through the cfg port while idle, then
// stream heights in row-major order on the s_ channel, one cell per transfer,
// with tlast on the final cell. Loading takes one cycle per cell.
// The final cell yields one result on the m_ channel: the water total and a
// size error flag. On a size or range error the result is valid in the cycle
// after the final transfer. Otherwise the fill runs: it clears the visited
// memory (n = rows * cols), scans the border, and for each popped cell pushes
// its unvisited neighbors, all heap reads going through the single heap
// RAM read port. No input is taken during the fill.
// The result waits in an output register; while m_tready is low the next
// grid still loads, but its final cell is held until the result is taken.
// Reset (rst_n low) clears all control state; rows and cols return to 1.
// Memory contents are not reset; the visited memory is cleared per grid.
// ----------------------------------------------------------------------------
module grid_basin_water_fill #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gbwf_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [gbwf_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gbwf_pkg::IN_HW-1:0]      s_tdata,   // cell_height
    input  logic                            s_tlast,   // last_cell
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gbwf_pkg::OUT_DW-1:0]     m_tdata    // water_total, size_error
);
    import gbwf_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int IDXW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNTW  = $clog2(CELLS + 2);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MRC   = (RW > CW) ? RW : CW;
    localparam int GW    = ((MRC > CFG_W) ? MRC : CFG_W) + 1;
    localparam int KW    = HEIGHT_BITS + RW + CW;
    localparam int SW    = ((WATER_W > HEIGHT_BITS) ? WATER_W : HEIGHT_BITS) + 1;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]       rows_reg, rows_next, cols_reg, cols_next;
    logic [CFG_W-1:0]       g_rows_reg, g_rows_next, g_cols_reg, g_cols_next;
    logic [CNTW-1:0]        n_reg, n_next, cnt_reg, cnt_next, clr_reg, clr_next;
    logic [CNTW-1:0]        size_reg, size_next, hi_reg, hi_next;
    logic [CNTW-1:0]        best_pos_reg, best_pos_next;
    logic [RW-1:0]          r_reg, r_next, nr_reg, nr_next;
    logic [CW-1:0]          c_reg, c_next, nc_reg, nc_next;
    logic [IDXW-1:0]        idx_reg, idx_next, nidx_reg, nidx_next;
    logic [KW-1:0]          key_reg, key_next, best_reg, best_next, top_reg, top_next;
    logic                   best_child_reg, best_child_next;
    logic [1:0]             k_reg, k_next;
    logic [WATER_W-1:0]     water_reg, water_next;
    logic                   ret_nb_reg, ret_nb_next;
    logic                   out_valid_reg, out_valid_next;
    logic [WATER_W-1:0]     out_water_reg, out_water_next;
    logic                   out_err_reg, out_err_next;

    // memory ports
    logic                   ht_we, v_we, v_wd, v_rdata, h_we;
    logic [IDXW-1:0]        ht_wa, ht_ra, v_wa, v_ra, h_wa, h_ra;
    logic [HEIGHT_BITS-1:0] ht_wd, ht_rdata;
    logic [KW-1:0]          h_wd, h_rdata;

    gbwf_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(CELLS)) u_height_ram (
        .clk(clk), .we(ht_we), .waddr(ht_wa), .wdata(ht_wd),
        .raddr(ht_ra), .rdata(ht_rdata)
    );

    gbwf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited_ram (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd),
        .raddr(v_ra), .rdata(v_rdata)
    );

    gbwf_ram #(.WIDTH(KW), .DEPTH(CELLS)) u_heap_ram (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd),
        .raddr(h_ra), .rdata(h_rdata)
    );

    // shared conditions
    logic                          in_fire, load_bad, border_cell, bs_last_col, bs_last_row;
    logic                          clr_done, l_in, r_in, pu_stop, nb_ok, ht_low;
    logic [CNTW-1:0]               cnt_inc, l_idx, r_idx, par_idx;
    logic [HEIGHT_BITS+IN_HW-1:0]  h_ext;
    logic [HEIGHT_BITS-1:0]        h_in, level;
    logic [RW-1:0]                 pr, nr_w;
    logic [CW-1:0]                 pc, nc_w;
    logic [SW-1:0]                 water_sum;
    logic [WATER_W-1:0]            water_sat;

    assign s_tready = (state_reg == S_LOAD) && (!out_valid_reg || !s_tlast);
    assign in_fire  = s_tvalid && s_tready;
    assign h_ext    = {{HEIGHT_BITS{1'b0}}, s_tdata};
    assign h_in     = h_ext[HEIGHT_BITS-1:0];
    assign cnt_inc  = (32'(cnt_reg) <= CELLS) ? cnt_reg + CNTW'(1) : cnt_reg;
    assign load_bad = (rows_reg == '0) || (32'(rows_reg) > MAX_ROWS) ||
                      (cols_reg == '0) || (32'(cols_reg) > MAX_COLS) ||
                      (32'(cnt_inc) != 32'(rows_reg) * 32'(cols_reg));

    assign bs_last_col = GW'(c_reg) == GW'(g_cols_reg) - GW'(1);
    assign bs_last_row = GW'(r_reg) == GW'(g_rows_reg) - GW'(1);
    assign border_cell = (r_reg == '0) || bs_last_row || (c_reg == '0) || bs_last_col;
    assign clr_done    = clr_reg == n_reg - CNTW'(1);

    assign l_idx   = CNTW'({hi_reg, 1'b1});
    assign r_idx   = l_idx + CNTW'(1);
    assign l_in    = (CNTW + 1)'({hi_reg, 1'b1}) < (CNTW + 1)'(size_reg);
    assign r_in    = (CNTW + 1)'({hi_reg, 1'b1}) + (CNTW + 1)'(1) < (CNTW + 1)'(size_reg);
    assign par_idx = (hi_reg - CNTW'(1)) >> 1;
    assign pu_stop = h_rdata <= key_reg;

    assign level = top_reg[KW-1:RW+CW];
    assign pr    = top_reg[RW+CW-1:CW];
    assign pc    = top_reg[CW-1:0];

    always_comb
    begin
        nb_ok = 1'b0;
        nr_w  = pr;
        nc_w  = pc;
        case (k_reg)
            2'd0:
            begin
                nb_ok = pr != '0;
                nr_w  = pr - RW'(1);
            end
            2'd1:
            begin
                nb_ok = GW'(pc) + GW'(1) < GW'(g_cols_reg);
                nc_w  = pc + CW'(1);
            end
            2'd2:
            begin
                nb_ok = GW'(pr) + GW'(1) < GW'(g_rows_reg);
                nr_w  = pr + RW'(1);
            end
            default:
            begin
                nb_ok = pc != '0;
                nc_w  = pc - CW'(1);
            end
        endcase
    end

    assign ht_low    = ht_rdata < level;
    assign water_sum = SW'(water_reg) + SW'(level - ht_rdata);
    assign water_sat = (water_sum > SW'(WATER_MAX)) ? WATER_MAX : water_sum[WATER_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_fire && s_tlast && !load_bad)
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:    state_next = clr_done ? S_BSCAN : S_CLEAR;
            S_BSCAN:    state_next = border_cell ? S_BPUSH : S_BNEXT;
            S_BPUSH:    state_next = S_PU_START;
            S_BNEXT:    state_next = (bs_last_col && bs_last_row) ? S_POP_RD0 : S_BSCAN;
            S_PU_START: state_next = S_PU_UP;
            S_PU_UP:
            begin
                if (hi_reg == '0)
                begin
                    state_next = ret_nb_reg ? S_NB_NEXT : S_BNEXT;
                end
                else
                begin
                    state_next = S_PU_CMP;
                end
            end
            S_PU_CMP:
            begin
                if (pu_stop)
                begin
                    state_next = ret_nb_reg ? S_NB_NEXT : S_BNEXT;
                end
                else
                begin
                    state_next = S_PU_UP;
                end
            end
            S_POP_RD0:  state_next = S_POP_RD1;
            S_POP_RD1:  state_next = S_POP_LAST;
            S_POP_LAST: state_next = S_SD_CHK;
            S_SD_CHK:   state_next = l_in ? S_SD_L : S_NB_ADDR;
            S_SD_L:     state_next = r_in ? S_SD_R : S_SD_DEC;
            S_SD_R:     state_next = S_SD_DEC;
            S_SD_DEC:   state_next = best_child_reg ? S_SD_CHK : S_NB_ADDR;
            S_NB_ADDR:  state_next = nb_ok ? S_NB_RD : S_NB_NEXT;
            S_NB_RD:    state_next = S_NB_CHK;
            S_NB_CHK:   state_next = v_rdata ? S_NB_NEXT : S_PU_START;
            S_NB_NEXT:
            begin
                if (k_reg != 2'd3)
                begin
                    state_next = S_NB_ADDR;
                end
                else
                begin
                    state_next = (size_reg == '0) ? S_DONE : S_POP_RD0;
                end
            end
            S_DONE:     state_next = S_LOAD;
            default:    state_next = S_LOAD;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        g_rows_next     = g_rows_reg;
        g_cols_next     = g_cols_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        clr_next        = clr_reg;
        size_next       = size_reg;
        hi_next         = hi_reg;
        best_pos_next   = best_pos_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        nr_next         = nr_reg;
        nc_next         = nc_reg;
        idx_next        = idx_reg;
        nidx_next       = nidx_reg;
        key_next        = key_reg;
        best_next       = best_reg;
        top_next        = top_reg;
        best_child_next = best_child_reg;
        k_next          = k_reg;
        water_next      = water_reg;
        ret_nb_next     = ret_nb_reg;
        out_valid_next  = out_valid_reg;
        out_water_next  = out_water_reg;
        out_err_next    = out_err_reg;

        ht_we = 1'b0;
        ht_wa = cnt_reg[IDXW-1:0];
        ht_wd = h_in;
        ht_ra = idx_reg;
        v_we  = 1'b0;
        v_wa  = idx_reg;
        v_wd  = 1'b1;
        v_ra  = nidx_reg;
        h_we  = 1'b0;
        h_wa  = hi_reg[IDXW-1:0];
        h_wd  = key_reg;
        h_ra  = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS: rows_next = cfg_wdata;
                CFG_COLS: cols_next = cfg_wdata;
                default:  rows_next = rows_reg;
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    ht_we = 32'(cnt_reg) < CELLS;
                    if (!s_tlast)
                    begin
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        cnt_next    = '0;
                        g_rows_next = rows_reg;
                        g_cols_next = cols_reg;
                        n_next      = CNTW'(32'(rows_reg) * 32'(cols_reg));
                        clr_next    = '0;
                        size_next   = '0;
                        water_next  = '0;
                        r_next      = '0;
                        c_next      = '0;
                        idx_next    = '0;
                        if (load_bad)
                        begin
                            out_valid_next = 1'b1;
                            out_water_next = '0;
                            out_err_next   = 1'b1;
                        end
                    end
                end
            end
            S_CLEAR:
            begin
                v_we     = 1'b1;
                v_wa     = clr_reg[IDXW-1:0];
                v_wd     = 1'b0;
                clr_next = clr_reg + CNTW'(1);
            end
            S_BSCAN:
            begin
                if (border_cell)
                begin
                    v_we = 1'b1;
                end
            end
            S_BPUSH:
            begin
                key_next    = {ht_rdata, r_reg, c_reg};
                ret_nb_next = 1'b0;
            end
            S_BNEXT:
            begin
                idx_next = idx_reg + IDXW'(1);
                if (bs_last_col)
                begin
                    c_next = '0;
                    r_next = r_reg + RW'(1);
                end
                else
                begin
                    c_next = c_reg + CW'(1);
                end
            end
            S_PU_START:
            begin
                hi_next   = size_reg;
                size_next = size_reg + CNTW'(1);
            end
            S_PU_UP:
            begin
                if (hi_reg == '0)
                begin
                    h_we = 1'b1;
                end
                else
                begin
                    h_ra = par_idx[IDXW-1:0];
                end
            end
            S_PU_CMP:
            begin
                h_we = 1'b1;
                if (!pu_stop)
                begin
                    h_wd    = h_rdata;
                    hi_next = par_idx;
                end
            end
            S_POP_RD0:
            begin
                h_ra = '0;
            end
            S_POP_RD1:
            begin
                top_next  = h_rdata;
                h_ra      = IDXW'(size_reg - CNTW'(1));
                size_next = size_reg - CNTW'(1);
            end
            S_POP_LAST:
            begin
                key_next = h_rdata;
                hi_next  = '0;
            end
            S_SD_CHK:
            begin
                k_next = 2'd0;
                if (l_in)
                begin
                    h_ra = l_idx[IDXW-1:0];
                end
                else
                begin
                    h_we = 1'b1;
                end
            end
            S_SD_L:
            begin
                if (h_rdata < key_reg)
                begin
                    best_next       = h_rdata;
                    best_child_next = 1'b1;
                    best_pos_next   = l_idx;
                end
                else
                begin
                    best_next       = key_reg;
                    best_child_next = 1'b0;
                end
                h_ra = r_idx[IDXW-1:0];
            end
            S_SD_R:
            begin
                if (h_rdata < best_reg)
                begin
                    best_next       = h_rdata;
                    best_child_next = 1'b1;
                    best_pos_next   = r_idx;
                end
            end
            S_SD_DEC:
            begin
                h_we   = 1'b1;
                k_next = 2'd0;
                if (best_child_reg)
                begin
                    h_wd    = best_reg;
                    hi_next = best_pos_reg;
                end
            end
            S_NB_ADDR:
            begin
                nr_next   = nr_w;
                nc_next   = nc_w;
                nidx_next = IDXW'(32'(nr_w) * 32'(g_cols_reg) + 32'(nc_w));
            end
            S_NB_RD:
            begin
                v_ra  = nidx_reg;
                ht_ra = nidx_reg;
            end
            S_NB_CHK:
            begin
                if (!v_rdata)
                begin
                    v_we        = 1'b1;
                    v_wa        = nidx_reg;
                    ret_nb_next = 1'b1;
                    if (ht_low)
                    begin
                        water_next = water_sat;
                        key_next   = {level, nr_reg, nc_reg};
                    end
                    else
                    begin
                        key_next = {ht_rdata, nr_reg, nc_reg};
                    end
                end
            end
            S_NB_NEXT:
            begin
                k_next = k_reg + 2'd1;
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                out_water_next = water_reg;
                out_err_next   = 1'b0;
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            rows_reg      <= CFG_W'(1);
            cols_reg      <= CFG_W'(1);
            cnt_reg       <= '0;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
            ret_nb_reg    <= 1'b0;
            k_reg         <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            cnt_reg       <= cnt_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
            ret_nb_reg    <= ret_nb_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_rows_reg     <= g_rows_next;
        g_cols_reg     <= g_cols_next;
        n_reg          <= n_next;
        clr_reg        <= clr_next;
        hi_reg         <= hi_next;
        best_pos_reg   <= best_pos_next;
        r_reg          <= r_next;
        c_reg          <= c_next;
        nr_reg         <= nr_next;
        nc_reg         <= nc_next;
        idx_reg        <= idx_next;
        nidx_reg       <= nidx_next;
        key_reg        <= key_next;
        best_reg       <= best_next;
        top_reg        <= top_next;
        best_child_reg <= best_child_next;
        water_reg      <= water_next;
        out_water_reg  <= out_water_next;
        out_err_reg    <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_err_reg, out_water_reg};

    // a finished result is never overwritten by the next grid
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_tlast |-> !out_valid_reg)
        else $error("result overwritten");

    // heap never grows past the grid capacity
    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(size_reg) <= CELLS)
        else $error("heap overflow");

    // a pop starts only on a non-empty heap
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP_RD0 |-> size_reg != '0)
        else $error("pop on empty heap");

    // the result is held while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_water_reg))
        else $error("stalled result changed");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for grid_basin_water_fill: height grids are streamed
// in, the trapped water is predicted by relaxing the water level of every
// cell down from the border, and each result transfer is checked against it.
// ----------------------------------------------------------------------------
module tb_top;
    import gbwf_pkg::*;

    localparam int CELLS     = 64 * 64;
    localparam int TB_MAX_RC = 64;
    localparam int CYC_LIMIT = 3000000;

    typedef struct packed {
        logic [WATER_W-1:0] water;
        logic               err;
    } basin_res_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = CFG_ROWS;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_HW-1:0]    s_tdata = '0;   // cell_height
    logic                s_tlast = 1'b0; // last_cell
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_DW-1:0]   m_tdata;        // water_total, size_error

    basin_res_t          water_q[$];
    logic [IN_HW-1:0]    height_mem[CELLS];
    int                  level_mem[CELLS];
    int                  cells_loaded = 0;
    int                  rows_reg = 1;
    int                  cols_reg = 1;
    int                  src_idle = 0;
    int                  snk_idle = 0;
    int                  fails = 0;
    int                  sent = 0;
    int                  cycles = 0;

    grid_basin_water_fill i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge clk)
    begin
        basin_res_t exp_r;
        if (m_tvalid && m_tready)
        begin
            if (water_q.size() == 0)
            begin
                $error("result transfer with no expected result");
                fails++;
            end
            else
            begin
                exp_r = water_q.pop_front();
                if (m_tdata[WATER_W-1:0] !== exp_r.water)
                begin
                    $error("water_total expected %0d actual %0d", exp_r.water,
                        m_tdata[WATER_W-1:0]);
                    fails++;
                end
                if (m_tdata[WATER_W] !== exp_r.err)
                begin
                    $error("size_error expected %0d actual %0d", exp_r.err,
                        m_tdata[WATER_W]);
                    fails++;
                end
            end
        end
    end

    function automatic logic [WATER_W-1:0] flood_water(int nr, int nc);
        int  sum;
        int  lo;
        int  nv;
        int  i;
        bit  moved;
        sum = 0;
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
            begin
                i = r * nc + c;
                if (r == 0 || r == nr - 1 || c == 0 || c == nc - 1)
                    level_mem[i] = height_mem[i];
                else
                    level_mem[i] = 65535;
            end
        do
        begin
            moved = 0;
            for (int r = 1; r < nr - 1; r++)
                for (int c = 1; c < nc - 1; c++)
                begin
                    i = r * nc + c;
                    lo = level_mem[i - nc];
                    if (level_mem[i + nc] < lo) lo = level_mem[i + nc];
                    if (level_mem[i - 1] < lo) lo = level_mem[i - 1];
                    if (level_mem[i + 1] < lo) lo = level_mem[i + 1];
                    nv = (height_mem[i] > lo) ? height_mem[i] : lo;
                    if (nv < level_mem[i])
                    begin
                        level_mem[i] = nv;
                        moved = 1;
                    end
                end
        end
        while (moved);
        for (int k = 0; k < nr * nc; k++)
            sum += level_mem[k] - height_mem[k];
        if (sum > WATER_MAX) sum = WATER_MAX;
        return sum[WATER_W-1:0];
    endfunction

    task automatic predict_cell(logic [IN_HW-1:0] h, logic last);
        basin_res_t res;
        bit         bad;
        if (cells_loaded < CELLS) height_mem[cells_loaded] = h;
        if (cells_loaded <= CELLS) cells_loaded++;
        if (last)
        begin
            bad = rows_reg == 0 || rows_reg > TB_MAX_RC || cols_reg == 0 ||
                cols_reg > TB_MAX_RC || cells_loaded != rows_reg * cols_reg;
            res.err   = bad;
            res.water = bad ? '0 : flood_water(rows_reg, cols_reg);
            water_q.push_back(res);
            cells_loaded = 0;
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_cell(logic [IN_HW-1:0] h, logic last);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = h;
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        predict_cell(h, last);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid = 1'b0;
        while (water_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val[CFG_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_ROWS) rows_reg = val & 7'h7F;
        else cols_reg = val & 7'h7F;
    endtask

    task automatic set_grid(int nr, int nc);
        drain();
        write_reg(CFG_ROWS, nr);
        write_reg(CFG_COLS, nc);
    endtask

    // mode 0 full range, 1 small heights, 2 extremes only
    task automatic send_grid(int count, int mode);
        logic [IN_HW-1:0] h;
        for (int k = 0; k < count; k++)
        begin
            case (mode)
                0: h = IN_HW'($urandom_range(65535));
                1: h = IN_HW'($urandom_range(15));
                default: h = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            endcase
            send_cell(h, k == count - 1);
        end
    endtask

    task automatic test_directed;
        send_cell(16'h0000, 1'b1);
        send_cell(16'hFFFF, 1'b1);
        set_grid(3, 3);
        for (int k = 0; k < 9; k++)
            send_cell(k == 4 ? 16'h0000 : 16'hFFFF, k == 8);
        send_grid(4, 0);
        send_grid(12, 0);
        set_grid(0, 3);
        send_grid(1, 0);
        set_grid(65, 127);
        send_grid(2, 0);
        set_grid(3, 0);
        send_grid(1, 0);
    endtask

    task automatic test_extremes;
        set_grid(64, 2);
        send_grid(128, 0);
        set_grid(2, 64);
        send_grid(128, 2);
        set_grid(5, 5);
        send_grid(25, 2);
    endtask

    task automatic test_overflow;
        set_grid(16, 16);
        send_grid(256, 1);
    endtask

    task automatic test_random(int s_idle, int m_idle, int quota);
        int stop;
        int nr;
        int nc;
        int n;
        stop = sent + quota;
        src_idle = s_idle;
        snk_idle = m_idle;
        while (sent < stop)
        begin
            if ($urandom_range(9) == 0)
            begin
                nr = $urandom_range(16);
                nc = $urandom_range(16);
            end
            else
            begin
                nr = $urandom_range(7, 1);
                nc = $urandom_range(7, 1);
            end
            set_grid(nr, nc);
            repeat ($urandom_range(4, 1))
            begin
                n = nr * nc;
                if ($urandom_range(9) == 0 || n == 0)
                    n = $urandom_range(n + 3, 1);
                send_grid(n, $urandom_range(2));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        src_idle = 13;
        snk_idle = 59;
        test_directed();
        test_extremes();
        test_overflow();
        test_random(13, 59, 230);
        test_random(59, 13, 230);
        test_random(0, 0, 230);
        drain();
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* grid_basin_water_fill.f */
rtl/gbwf_pkg.sv
rtl/gbwf_ram.sv
rtl/grid_basin_water_fill.sv
sim/tb_top.sv
